// ===== rtl/pfa_pkg.sv =====
// Shared constants, codes and types of the bitmap page frame allocator.
package pfa_pkg;

  localparam int MAX_FRAMES = 65536;
  localparam int WORD_BITS  = 32;
  localparam int PAGE_SHIFT = 12;
  localparam int MAP_WORDS  = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;

  localparam int BIT_W   = $clog2(WORD_BITS);
  localparam int WIDX_W  = $clog2(MAP_WORDS);
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int CFG_W   = 17;
  localparam int ADDR_W  = 32;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;
  localparam int OP_W    = 2;
  localparam int FRAME_W = ADDR_W - PAGE_SHIFT;
  localparam int END_W   = FRAME_W + 2;

  localparam logic [CFG_W-1:0]  CFG_RST   = CFG_W'(65536);
  localparam logic [BIT_W-1:0]  TOP_BIT   = BIT_W'(WORD_BITS - 1);
  localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(MAP_WORDS - 1);
  localparam logic [ADDR_W:0]   PAGE_RND  = (ADDR_W + 1)'((1 << PAGE_SHIFT) - 1);

  // request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd2;

  // result status
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  // bit unit operations
  localparam logic [OP_W-1:0] OP_SET   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLR   = 2'd1;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] length;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] page_addr;
    logic [STAT_W-1:0] status;
  } res_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 found;
    logic [BIT_W-1:0]     idx;
  } bit_res_t;

endpackage

// ===== rtl/pfa_bit_unit.sv =====
// Shared word unit: range mask, lowest free bit search and word update.
module pfa_bit_unit (
  input  logic [pfa_pkg::OP_W-1:0]      op,
  input  logic [pfa_pkg::BIT_W-1:0]     lo,
  input  logic [pfa_pkg::BIT_W-1:0]     hi,
  input  logic [pfa_pkg::WORD_BITS-1:0] word,
  output pfa_pkg::bit_res_t             res
);

  logic [pfa_pkg::WORD_BITS-1:0] rmask;
  logic [pfa_pkg::WORD_BITS-1:0] free_bits;
  logic [pfa_pkg::WORD_BITS-1:0] one_hot;
  logic [pfa_pkg::BIT_W-1:0]     idx;

  always_comb begin
    rmask = ({pfa_pkg::WORD_BITS{1'b1}} << lo) &
            ({pfa_pkg::WORD_BITS{1'b1}} >> (pfa_pkg::TOP_BIT - hi));
    free_bits = ~word & rmask;
    idx = '0;
    // lowest free bit wins
    for (int i = pfa_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        idx = pfa_pkg::BIT_W'(i);
      end
    end
    one_hot = pfa_pkg::WORD_BITS'(1) << idx;
    res.found = |free_bits;
    res.idx   = idx;
    case (op)
      pfa_pkg::OP_SET:   res.word = word | rmask;
      pfa_pkg::OP_CLR:   res.word = word & ~rmask;
      pfa_pkg::OP_ALLOC: res.word = word | one_hot;
      default:           res.word = word;
    endcase
  end

endmodule

// ===== rtl/pfa_engine.sv =====
// Request sequencer with the used bitmap memory and its clearing sweep.
module pfa_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      req_valid,
  input  pfa_pkg::req_t             req,
  output logic                      req_ready,
  input  logic [pfa_pkg::CNT_W-1:0] live,
  output logic                      res_valid,
  output pfa_pkg::res_t             res,
  input  logic                      res_ready
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RS1  = 3'd2;
  localparam logic [2:0] S_RS2  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_EV   = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [pfa_pkg::WORD_BITS-1:0] mem [pfa_pkg::MAP_WORDS];
  logic [pfa_pkg::WORD_BITS-1:0] rd_data_r;
  logic                          wr_en;
  logic [pfa_pkg::WIDX_W-1:0]    wr_addr;
  logic [pfa_pkg::WORD_BITS-1:0] wr_data;

  logic [2:0]                  state_r,   state_nxt;
  logic [pfa_pkg::WIDX_W-1:0]  cur_w_r,   cur_w_nxt;
  logic [pfa_pkg::WIDX_W-1:0]  last_w_r,  last_w_nxt;
  logic [pfa_pkg::BIT_W-1:0]   lo_r,      lo_nxt;
  logic [pfa_pkg::BIT_W-1:0]   last_hi_r, last_hi_nxt;
  logic [pfa_pkg::OP_W-1:0]    op_r,      op_nxt;
  logic [pfa_pkg::STAT_W-1:0]  status_r,  status_nxt;
  logic [pfa_pkg::ADDR_W-1:0]  page_r,    page_nxt;
  logic [pfa_pkg::CNT_W-1:0]   live_r,    live_nxt;
  logic [pfa_pkg::FRAME_W-1:0] start_r,   start_nxt;
  logic [pfa_pkg::FRAME_W:0]   n_r,       n_nxt;
  logic [pfa_pkg::END_W-1:0]   end_r,     end_nxt;

  logic [pfa_pkg::FRAME_W-1:0] frame_in;
  logic [pfa_pkg::ADDR_W:0]    len_rnd;
  logic [pfa_pkg::CNT_W-1:0]   live_m1;
  logic [pfa_pkg::END_W-1:0]   live_ext;
  logic [pfa_pkg::END_W-1:0]   end_clip;
  logic [pfa_pkg::END_W-1:0]   end_m1;
  logic [pfa_pkg::BIT_W-1:0]   hi;
  pfa_pkg::bit_res_t           unit_res;

  pfa_bit_unit u_bit (
    .op   (op_r),
    .lo   (lo_r),
    .hi   (hi),
    .word (rd_data_r),
    .res  (unit_res)
  );

  always_ff @(posedge clk) begin
    rd_data_r <= mem[cur_w_r];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign req_ready     = (state_r == S_IDLE);
  assign res_valid     = (state_r == S_DONE);
  assign res.page_addr = page_r;
  assign res.status    = status_r;

  always_comb begin
    frame_in = req.addr[pfa_pkg::ADDR_W-1:pfa_pkg::PAGE_SHIFT];
    len_rnd  = {1'b0, req.length} + pfa_pkg::PAGE_RND;
    live_m1  = live - pfa_pkg::CNT_W'(1);
    live_ext = pfa_pkg::END_W'(live_r);
    end_clip = (end_r > live_ext) ? live_ext : end_r;
    end_m1   = end_clip - pfa_pkg::END_W'(1);
    hi       = (cur_w_r == last_w_r) ? last_hi_r : pfa_pkg::TOP_BIT;

    state_nxt   = state_r;
    cur_w_nxt   = cur_w_r;
    last_w_nxt  = last_w_r;
    lo_nxt      = lo_r;
    last_hi_nxt = last_hi_r;
    op_nxt      = op_r;
    status_nxt  = status_r;
    page_nxt    = page_r;
    live_nxt    = live_r;
    start_nxt   = start_r;
    n_nxt       = n_r;
    end_nxt     = end_r;
    wr_en       = 1'b0;
    wr_addr     = cur_w_r;
    wr_data     = unit_res.word;

    case (state_r)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_data = '0;
        if (cur_w_r == pfa_pkg::LAST_WORD) begin
          cur_w_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          cur_w_nxt = cur_w_r + pfa_pkg::WIDX_W'(1);
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          live_nxt   = live;
          page_nxt   = '0;
          status_nxt = pfa_pkg::STAT_OK;
          case (req.kind)
            pfa_pkg::KIND_ALLOC: begin
              op_nxt      = pfa_pkg::OP_ALLOC;
              cur_w_nxt   = '0;
              lo_nxt      = '0;
              last_w_nxt  = live_m1[pfa_pkg::BIT_W +: pfa_pkg::WIDX_W];
              last_hi_nxt = live_m1[pfa_pkg::BIT_W-1:0];
              if (live == '0) begin
                status_nxt = pfa_pkg::STAT_FULL;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_RD;
              end
            end
            pfa_pkg::KIND_FREE: begin
              op_nxt      = pfa_pkg::OP_CLR;
              cur_w_nxt   = frame_in[pfa_pkg::BIT_W +: pfa_pkg::WIDX_W];
              last_w_nxt  = frame_in[pfa_pkg::BIT_W +: pfa_pkg::WIDX_W];
              lo_nxt      = frame_in[pfa_pkg::BIT_W-1:0];
              last_hi_nxt = frame_in[pfa_pkg::BIT_W-1:0];
              if (pfa_pkg::END_W'(frame_in) >= pfa_pkg::END_W'(live)) begin
                status_nxt = pfa_pkg::STAT_RANGE;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_RD;
              end
            end
            pfa_pkg::KIND_RESERVE: begin
              op_nxt    = pfa_pkg::OP_SET;
              start_nxt = frame_in;
              n_nxt     = len_rnd[pfa_pkg::ADDR_W:pfa_pkg::PAGE_SHIFT];
              state_nxt = S_RS1;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_RS1: begin
        end_nxt = pfa_pkg::END_W'(start_r) + pfa_pkg::END_W'(n_r);
        state_nxt = S_RS2;
      end
      S_RS2: begin
        if ((n_r != '0) && (end_r > live_ext)) begin
          status_nxt = pfa_pkg::STAT_RANGE;
        end
        cur_w_nxt   = start_r[pfa_pkg::BIT_W +: pfa_pkg::WIDX_W];
        lo_nxt      = start_r[pfa_pkg::BIT_W-1:0];
        last_w_nxt  = end_m1[pfa_pkg::BIT_W +: pfa_pkg::WIDX_W];
        last_hi_nxt = end_m1[pfa_pkg::BIT_W-1:0];
        // empty or fully clipped range touches nothing
        if (pfa_pkg::END_W'(start_r) < end_clip) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RD: begin
        state_nxt = S_EV;
      end
      S_EV: begin
        if (op_r == pfa_pkg::OP_ALLOC) begin
          if (unit_res.found) begin
            wr_en      = 1'b1;
            page_nxt   = pfa_pkg::ADDR_W'({cur_w_r, unit_res.idx}) << pfa_pkg::PAGE_SHIFT;
            status_nxt = pfa_pkg::STAT_OK;
            state_nxt  = S_DONE;
          end else if (cur_w_r == last_w_r) begin
            status_nxt = pfa_pkg::STAT_FULL;
            state_nxt  = S_DONE;
          end else begin
            cur_w_nxt = cur_w_r + pfa_pkg::WIDX_W'(1);
            state_nxt = S_RD;
          end
        end else begin
          wr_en = 1'b1;
          if (cur_w_r == last_w_r) begin
            state_nxt = S_DONE;
          end else begin
            cur_w_nxt = cur_w_r + pfa_pkg::WIDX_W'(1);
            lo_nxt    = '0;
            state_nxt = S_RD;
          end
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cur_w_r <= '0;
    end else begin
      state_r <= state_nxt;
      cur_w_r <= cur_w_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_w_r  <= last_w_nxt;
    lo_r      <= lo_nxt;
    last_hi_r <= last_hi_nxt;
    op_r      <= op_nxt;
    status_r  <= status_nxt;
    page_r    <= page_nxt;
    live_r    <= live_nxt;
    start_r   <= start_nxt;
    n_r       <= n_nxt;
    end_r     <= end_nxt;
  end

endmodule

// ===== rtl/bitmap_page_frame_allocator_top.sv =====
// Top level: stream ports, frame count register and result output register.
// Allocate scans bitmap words up to the frame count for the lowest free frame.
// Free touches one word, none if the frame is past the count; Reserve, each word
// of its range inside the count. One request in flight; the registered bitmap
// read paces the word loop. Reset sets the frame count to 65536, then sweeps the
// 2048-word bitmap to zero, one word a cycle; in_tready stays low meanwhile.
module bitmap_page_frame_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: frame count
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] addr, [63:32] length
  input  logic [1:0]  in_tuser,   // [1:0] kind
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] page_addr, [33:32] status, rest zero
);

  logic [pfa_pkg::CFG_W-1:0] frame_count_r;
  logic [pfa_pkg::ADDR_W-1:0] cfg_ext;
  logic [pfa_pkg::ADDR_W-1:0] live_ext;
  logic [pfa_pkg::CNT_W-1:0]  live;

  pfa_pkg::req_t req;
  pfa_pkg::res_t res;
  logic          res_valid;
  logic          res_ready;

  logic          out_valid_r;
  pfa_pkg::res_t out_res_r;

  // frame count write, taken at any edge with cfg_we
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= pfa_pkg::CFG_RST;
    end else if (cfg_we) begin
      frame_count_r <= cfg_wdata;
    end
  end

  // counts above the bitmap size act as the bitmap size
  always_comb begin
    cfg_ext  = pfa_pkg::ADDR_W'(frame_count_r);
    live_ext = (cfg_ext > pfa_pkg::ADDR_W'(pfa_pkg::MAX_FRAMES)) ?
               pfa_pkg::ADDR_W'(pfa_pkg::MAX_FRAMES) : cfg_ext;
    live     = live_ext[pfa_pkg::CNT_W-1:0];
  end

  assign req.kind   = in_tuser;
  assign req.addr   = in_tdata[31:0];
  assign req.length = in_tdata[63:32];

  pfa_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req       (req),
    .req_ready (in_tready),
    .live      (live),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // output word register; the engine hands over when it is empty or draining
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.status, out_res_r.page_addr};

endmodule
